// ----- rtl/core/can_sa_pkg.sv -----
// can_sa_pkg: shared types and constants of the bus self-addressing block
// beat payload structs, request and token codes, register indexes and defaults
// no dependencies
package can_sa_pkg;

   // default sizing
   localparam int CAN_SA_ADDR_BITS  = 7;
   localparam int CAN_SA_GUID_BYTES = 16;

   // byte counter over the guid, wide enough for the largest guid
   localparam int GUID_IDX_BITS = 4;

   // address search constants
   localparam int ROT_CONST = 'h64;
   localparam int ADDR_TOP  = 120;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STATIC_MODE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GUID_LOW        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GUID_HIGH       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLAIM_DELAY     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEACON_DELAY    = 3'd5;

   localparam logic [15:0] CLAIM_DELAY_RESET  = 16'd100;
   localparam logic [15:0] BEACON_DELAY_RESET = 16'd1200;

   // request codes
   localparam logic [1:0] REQ_RESTART = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_TOKEN   = 2'd2;

   // token key codes
   localparam logic [1:0] KIND_OTHER        = 2'd0;
   localparam logic [1:0] KIND_ADDR_REQUEST = 2'd1;
   localparam logic [1:0] KIND_ADDR_IN_USE  = 2'd2;

   // input beat
   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_time;
      logic [1:0]  token_kind;
      logic [31:0] token_value;
      logic [7:0]  token_sender;
   } req_beat_type;

   // result beat
   typedef struct packed {
      logic        send_valid;
      logic [1:0]  send_kind;
      logic [6:0]  send_value;
      logic [6:0]  current_address;
      logic        address_ok;
      logic        beacon_start;
      logic [31:0] beacon_due;
   } rsp_beat_type;

endpackage

// ----- rtl/core/can_sa_ifs.sv -----
// can_sa_ifs: valid/ready channel interfaces for request and result beats
// depends on can_sa_pkg for the beat structs

// request channel
interface can_sa_req_if
   import can_sa_pkg::*;
();
   logic         valid;
   logic         ready;
   req_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// result channel
interface can_sa_rsp_if
   import can_sa_pkg::*;
();
   logic         valid;
   logic         ready;
   rsp_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/can_self_address_claim.sv -----
// can_self_address_claim: bus node self-addressing with guid based address search
// depends on can_sa_pkg and the channel interfaces in can_sa_ifs
// every request beat gives exactly one result beat
//
// Each request beat (restart, time tick or received token) yields one result beat.
// Restarts, tokens and ticks that do not start a proposal have their result in the
// output register on the next cycle; a new beat is taken as soon as that register
// is free or being drained. A tick that proposes a new address runs the address
// search on a single byte accumulator, one guid byte per cycle; a search takes
// between 1 and ADDR_BITS * 2**ADDR_BITS + 1 tries of GUID_BYTES bytes each, and no
// request is taken until it has ended and its result is registered. Configuration
// registers are written through csr_we, csr_index and csr_wdata and should only be
// changed while the block is idle.
module can_self_address_claim
   import can_sa_pkg::*;
#(
   parameter int ADDR_BITS  = CAN_SA_ADDR_BITS,
   parameter int GUID_BYTES = CAN_SA_GUID_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   can_sa_req_if.sink                req_port,
   can_sa_rsp_if.source              rsp_port,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int ROT_BITS = $clog2(ADDR_BITS);
   localparam int TRIES    = ADDR_BITS * (2 ** ADDR_BITS) + 1;
   localparam int TRY_BITS = $clog2(TRIES);

   localparam logic [ADDR_BITS-1:0]     ADDR_TOP_V = ADDR_BITS'(ADDR_TOP);
   localparam logic [ADDR_BITS-1:0]     ROT_BASE   = ADDR_BITS'(ROT_CONST);
   localparam logic [ROT_BITS-1:0]      ROT_LAST   = ROT_BITS'(ADDR_BITS - 1);
   localparam logic [GUID_IDX_BITS-1:0] BYTE_LAST  = GUID_IDX_BITS'(GUID_BYTES - 1);
   localparam logic [TRY_BITS-1:0]      TRY_LAST   = TRY_BITS'(TRIES - 1);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // address is usable when in range or fixed
   function automatic logic addr_ok_f(input logic [ADDR_BITS-1:0] a, input logic st);
      return ((a != '0) && (a <= ADDR_TOP_V)) || st;
   endfunction

   state_type state_ff, state_in;

   // configuration registers
   logic [6:0]  initial_address_ff, initial_address_in;
   logic        static_mode_ff, static_mode_in;
   logic [63:0] guid_low_ff, guid_low_in;
   logic [63:0] guid_high_ff, guid_high_in;
   logic [15:0] claim_delay_ff, claim_delay_in;
   logic [15:0] beacon_delay_ff, beacon_delay_in;

   // addressing state
   logic [ADDR_BITS-1:0] working_ff, working_in;
   logic [ADDR_BITS-1:0] proposed_ff, proposed_in;
   logic [ROT_BITS-1:0]  rot_ff, rot_in;
   logic [ADDR_BITS-1:0] offset_ff, offset_in;
   logic [31:0]          deadline_ff, deadline_in;

   // search unit
   logic [ADDR_BITS-1:0]     acc_ff, acc_in;
   logic [GUID_IDX_BITS-1:0] idx_ff, idx_in;
   logic [TRY_BITS-1:0]      tries_ff, tries_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   req_beat_type           req;
   logic [127:0]           guid_all;
   logic [7:0]             guid_byte;
   logic [2*ADDR_BITS-1:0] rot_pair;
   logic [ADDR_BITS-1:0]   rot_mask;
   logic [ADDR_BITS-1:0]   acc_sum;
   logic [ADDR_BITS-1:0]   cand;
   logic                   cand_ok;
   logic [31:0]            since_deadline;

   assign req            = req_port.data;
   assign req_port.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_port.ready);
   assign req_fire       = req_port.valid && req_port.ready;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_data_ff;

   // single byte accumulator of the address search
   assign guid_all  = {guid_high_ff, guid_low_ff};
   assign guid_byte = guid_all[{idx_ff, 3'b000} +: 8];
   assign rot_pair  = {ROT_BASE, ROT_BASE} >> rot_ff;
   assign rot_mask  = rot_pair[ADDR_BITS-1:0];
   assign acc_sum   = acc_ff + (guid_byte[ADDR_BITS-1:0] ^ rot_mask);
   assign cand      = acc_sum + offset_ff;
   assign cand_ok   = (cand != '0) && (cand <= ADDR_TOP_V);

   assign since_deadline = req.now_time - deadline_ff;

   // next state
   always_comb begin
      state_in           = state_ff;
      initial_address_in = initial_address_ff;
      static_mode_in     = static_mode_ff;
      guid_low_in        = guid_low_ff;
      guid_high_in       = guid_high_ff;
      claim_delay_in     = claim_delay_ff;
      beacon_delay_in    = beacon_delay_ff;
      working_in         = working_ff;
      proposed_in        = proposed_ff;
      rot_in             = rot_ff;
      offset_in          = offset_ff;
      deadline_in        = deadline_ff;
      acc_in             = acc_ff;
      idx_in             = idx_ff;
      tries_in           = tries_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_data_in        = rsp_data_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_ADDRESS: initial_address_in = csr_wdata[6:0];
            CSR_STATIC_MODE:     static_mode_in     = csr_wdata[0];
            CSR_GUID_LOW:        guid_low_in        = csr_wdata;
            CSR_GUID_HIGH:       guid_high_in       = csr_wdata;
            CSR_CLAIM_DELAY:     claim_delay_in     = csr_wdata[15:0];
            CSR_BEACON_DELAY:    beacon_delay_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      // result beat taken
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_data_in              = '0;
               rsp_valid_in             = 1'b1;
               case (req.req_type)
                  REQ_RESTART: begin
                     working_in  = ADDR_BITS'(initial_address_ff);
                     proposed_in = '0;
                     rot_in      = '0;
                     offset_in   = '0;
                  end
                  REQ_TICK: begin
                     if (!addr_ok_f(working_ff, static_mode_ff)) begin
                        if (proposed_ff == '0) begin
                           // start a search, result comes when it ends
                           deadline_in  = req.now_time + 32'(claim_delay_ff);
                           acc_in       = '0;
                           idx_in       = '0;
                           tries_in     = '0;
                           rsp_valid_in = 1'b0;
                           state_in     = ST_SEARCH;
                        end else if (!since_deadline[31]) begin
                           // claim deadline passed: adopt the proposal
                           working_in               = proposed_ff;
                           proposed_in              = '0;
                           rsp_data_in.send_valid   = 1'b1;
                           rsp_data_in.send_kind    = KIND_ADDR_IN_USE;
                           rsp_data_in.send_value   = 7'(proposed_ff);
                           rsp_data_in.beacon_start = 1'b1;
                           rsp_data_in.beacon_due   = req.now_time + 32'(beacon_delay_ff);
                        end
                     end
                  end
                  REQ_TOKEN: begin
                     if (((req.token_kind == KIND_ADDR_IN_USE) &&
                          (req.token_value == 32'(proposed_ff))) ||
                         ((working_ff != '0) && (8'(working_ff) == req.token_sender) &&
                          !static_mode_ff)) begin
                        // conflict: restart addressing
                        working_in  = '0;
                        proposed_in = '0;
                     end else if ((req.token_kind == KIND_ADDR_REQUEST) &&
                                  (req.token_value == 32'(working_ff))) begin
                        rsp_data_in.send_valid = 1'b1;
                        rsp_data_in.send_kind  = KIND_ADDR_IN_USE;
                        rsp_data_in.send_value = 7'(working_ff);
                     end
                  end
                  default: ;
               endcase
               rsp_data_in.current_address = 7'(working_in);
               rsp_data_in.address_ok      = addr_ok_f(working_in, static_mode_ff);
            end
         end
         ST_SEARCH: begin
            if (idx_ff == BYTE_LAST) begin
               // one try done: step rotation, and offset when rotation wraps
               acc_in   = '0;
               idx_in   = '0;
               tries_in = tries_ff + 1'b1;
               if (rot_ff == ROT_LAST) begin
                  rot_in    = '0;
                  offset_in = offset_ff + 1'b1;
               end else begin
                  rot_in = rot_ff + 1'b1;
               end
               if (cand_ok || (tries_ff == TRY_LAST)) begin
                  proposed_in                 = cand_ok ? cand : ADDR_BITS'(1);
                  rsp_data_in                 = '0;
                  rsp_data_in.send_valid      = 1'b1;
                  rsp_data_in.send_kind       = KIND_ADDR_REQUEST;
                  rsp_data_in.send_value      = cand_ok ? 7'(cand) : 7'd1;
                  rsp_data_in.current_address = 7'(working_ff);
                  rsp_data_in.address_ok      = addr_ok_f(working_ff, static_mode_ff);
                  rsp_valid_in                = 1'b1;
                  state_in                    = ST_IDLE;
               end
            end else begin
               acc_in = acc_sum;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      tries_ff    <= tries_in;
      if (reset) begin
         state_ff           <= ST_IDLE;
         initial_address_ff <= '0;
         static_mode_ff     <= 1'b0;
         guid_low_ff        <= '0;
         guid_high_ff       <= '0;
         claim_delay_ff     <= CLAIM_DELAY_RESET;
         beacon_delay_ff    <= BEACON_DELAY_RESET;
         working_ff         <= '0;
         proposed_ff        <= '0;
         rot_ff             <= '0;
         offset_ff          <= '0;
         deadline_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         initial_address_ff <= initial_address_in;
         static_mode_ff     <= static_mode_in;
         guid_low_ff        <= guid_low_in;
         guid_high_ff       <= guid_high_in;
         claim_delay_ff     <= claim_delay_in;
         beacon_delay_ff    <= beacon_delay_in;
         working_ff         <= working_in;
         proposed_ff        <= proposed_in;
         rot_ff             <= rot_in;
         offset_ff          <= offset_in;
         deadline_ff        <= deadline_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

endmodule
